// ===== sv/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants, types and functions of the CRC-16 escaped frame codec.
// ----------------------------------------------------------------------------
package cfc_pkg;

  localparam int unsigned MAX_PAD_RUN = 64;
  localparam int unsigned PAD_W       = $clog2(MAX_PAD_RUN + 1);
  localparam int unsigned HELD_MAX    = 5;
  localparam int unsigned HELD_W      = 3;
  localparam int unsigned TAIL_DEPTH  = 3;

  localparam logic [7:0] BYTE_LPAREN = 8'h28;
  localparam logic [7:0] BYTE_CR     = 8'h0d;
  localparam logic [7:0] BYTE_LF     = 8'h0a;

  localparam logic [15:0] NIB_TAB [16] = '{
    16'h0000, 16'h1021, 16'h2042, 16'h3063, 16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
    16'h8108, 16'h9129, 16'ha14a, 16'hb16b, 16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
  };

  typedef struct packed {
    logic       clear;
    logic       start;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [15:0] crc_nibble(input logic [15:0] c, input logic [3:0] nib);
    logic [3:0] idx;
    idx = c[15:12] ^ nib;
    return {c[11:0], 4'b0000} ^ NIB_TAB[idx];
  endfunction

  function automatic logic [7:0] escape_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == BYTE_LPAREN || b == BYTE_CR || b == BYTE_LF) begin
      r = b + 8'd1;
    end
    return r;
  endfunction

endpackage

// ===== sv/cfc_crc_nib.sv =====
// ----------------------------------------------------------------------------
// cfc_crc_nib
// Running CRC-16 register, advanced one nibble per cycle, high nibble first.
// ----------------------------------------------------------------------------
module cfc_crc_nib (
  input  logic              clk,
  input  logic              rst_n,
  input  cfc_pkg::crc_ctl_t ctl,
  output logic [15:0]       crc,
  output logic              busy
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  lo_nib_r, lo_nib_nxt;
  logic        busy_r, busy_nxt;
  logic [15:0] crc_base;

  always_comb begin
    crc_base   = ctl.clear ? 16'h0000 : crc_r;
    crc_nxt    = crc_base;
    lo_nib_nxt = lo_nib_r;
    busy_nxt   = 1'b0;
    if (busy_r) begin
      crc_nxt = cfc_pkg::crc_nibble(crc_r, lo_nib_r);
    end else if (ctl.start) begin
      crc_nxt    = cfc_pkg::crc_nibble(crc_base, ctl.data[7:4]);
      lo_nib_nxt = ctl.data[3:0];
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= 16'h0000;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      busy_r <= busy_nxt;
    end
    lo_nib_r <= lo_nib_nxt;
  end

  assign crc  = crc_r;
  assign busy = busy_r;

endmodule

// ===== sv/crc16_escaped_frame_codec_core.sv =====
// ----------------------------------------------------------------------------
// crc16_escaped_frame_codec_core
// Frames payload bytes with an escaped CRC-16 trailer, or checks response bytes.
// ----------------------------------------------------------------------------
// Framing: each accepted item is echoed from S_F_ECHO; an item marked last then
// passes S_F_HI, S_F_LO and S_F_CR (four results: byte, CRC high, CRC low, CR).
// Checking: a zero item goes straight to S_C_EMIT; a nonzero item is committed in
// S_C_COMMIT after each pending zero, as the nibble-serial CRC unit replays each
// byte. A new item is accepted only in S_IDLE, once its last result is registered.
// Reset (rst_n low, synchronous) clears mode, CRC, tail window and all counters.
module crc16_escaped_frame_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,    // mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] data_byte
  input  logic       in_tuser,     // [0] first
  input  logic       in_tlast,     // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // [7:0] out_byte
  output logic [1:0] out_tuser,    // [0] frame_ok, [1] pad_overflow
  output logic       out_tlast     // end_of_run
);

  typedef enum logic [2:0] {
    S_IDLE, S_F_ECHO, S_F_HI, S_F_LO, S_F_CR, S_C_COMMIT, S_C_EMIT
  } state_t;

  localparam logic [cfc_pkg::PAD_W-1:0] PAD_MAX =
    cfc_pkg::PAD_W'(cfc_pkg::MAX_PAD_RUN);
  localparam logic [cfc_pkg::HELD_W-1:0] HELD_LIM =
    cfc_pkg::HELD_W'(cfc_pkg::HELD_MAX);

  state_t                    state_r, state_nxt;
  logic                      mode_r, mode_nxt;
  logic [7:0]                byte_r, byte_nxt;
  logic                      last_r, last_nxt;
  logic [7:0]                tail_r [cfc_pkg::TAIL_DEPTH];
  logic [7:0]                tail_nxt [cfc_pkg::TAIL_DEPTH];
  logic [cfc_pkg::HELD_W-1:0] held_r, held_nxt;
  logic [cfc_pkg::PAD_W-1:0]  pad_r, pad_nxt;
  logic                      status_r, status_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      ov_r, ov_nxt;
  logic [7:0]                od_r, od_nxt;
  logic [1:0]                ou_r, ou_nxt;
  logic                      ol_r, ol_nxt;

  cfc_pkg::crc_ctl_t crc_ctl;
  logic [15:0]       crc;
  logic              crc_busy;
  logic              accept;
  logic              out_free;
  logic              status_calc;

  cfc_crc_nib u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .crc  (crc),
    .busy (crc_busy)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  assign status_calc = (held_r >= HELD_LIM) &&
                       (cfc_pkg::escape_byte(crc[15:8]) == tail_r[0]) &&
                       (cfc_pkg::escape_byte(crc[7:0]) == tail_r[1]);

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = cfg_we ? cfg_wdata : mode_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    tail_nxt   = tail_r;
    held_nxt   = held_r;
    pad_nxt    = pad_r;
    status_nxt = status_r;
    ovf_nxt    = ovf_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    ou_nxt     = ou_r;
    ol_nxt     = ol_r;
    crc_ctl    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (in_tuser) begin
            crc_ctl.clear = 1'b1;
            tail_nxt      = '{default: 8'h00};
            held_nxt      = '0;
            pad_nxt       = '0;
            status_nxt    = 1'b0;
            ovf_nxt       = 1'b0;
          end
          if (!mode_r) begin
            crc_ctl.start = 1'b1;
            crc_ctl.data  = in_tdata;
            state_nxt     = S_F_ECHO;
          end else if (in_tdata == 8'h00) begin
            if (pad_nxt < PAD_MAX) begin
              pad_nxt = pad_nxt + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            state_nxt = S_C_EMIT;
          end else begin
            state_nxt = S_C_COMMIT;
          end
        end
      end
      S_F_ECHO: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = byte_r;
          ou_nxt    = 2'b00;
          ol_nxt    = !last_r;
          state_nxt = last_r ? S_F_HI : S_IDLE;
        end
      end
      S_F_HI: begin
        if (out_free && !crc_busy) begin
          ov_nxt    = 1'b1;
          od_nxt    = cfc_pkg::escape_byte(crc[15:8]);
          ou_nxt    = 2'b00;
          ol_nxt    = 1'b0;
          state_nxt = S_F_LO;
        end
      end
      S_F_LO: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          od_nxt    = cfc_pkg::escape_byte(crc[7:0]);
          ou_nxt    = 2'b00;
          ol_nxt    = 1'b0;
          state_nxt = S_F_CR;
        end
      end
      S_F_CR: begin
        if (out_free) begin
          ov_nxt        = 1'b1;
          od_nxt        = cfc_pkg::BYTE_CR;
          ou_nxt        = 2'b00;
          ol_nxt        = 1'b1;
          crc_ctl.clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_C_COMMIT: begin
        if (!crc_busy) begin
          if (held_r >= cfc_pkg::HELD_W'(cfc_pkg::TAIL_DEPTH)) begin
            crc_ctl.start = 1'b1;
            crc_ctl.data  = tail_r[0];
          end
          tail_nxt[0] = tail_r[1];
          tail_nxt[1] = tail_r[2];
          if (held_r < HELD_LIM) begin
            held_nxt = held_r + 1'b1;
          end
          if (pad_r != '0) begin
            tail_nxt[2] = 8'h00;
            pad_nxt     = pad_r - 1'b1;
          end else begin
            tail_nxt[2] = byte_r;
            state_nxt   = S_C_EMIT;
          end
        end
      end
      S_C_EMIT: begin
        if (out_free && !crc_busy) begin
          if (byte_r != 8'h00) begin
            status_nxt = status_calc;
          end
          ov_nxt    = 1'b1;
          od_nxt    = byte_r;
          ou_nxt    = {ovf_r, status_nxt};
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= 1'b0;
      tail_r   <= '{default: 8'h00};
      held_r   <= '0;
      pad_r    <= '0;
      status_r <= 1'b0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      tail_r   <= tail_nxt;
      held_r   <= held_nxt;
      pad_r    <= pad_nxt;
      status_r <= status_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_LIM)
    else $error("held count past saturation");

  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r <= PAD_MAX)
    else $error("pad run past bound");

  a_frame_crc_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !mode_r |=> crc_busy)
    else $error("framing item did not start the CRC unit");

  a_ovf_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(pad_r) == PAD_MAX)
    else $error("overflow set below the pad bound");

  a_frame_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !mode_r |-> out_tuser == 2'b00)
    else $error("status flags on a framing result");

endmodule
